>>> hw/rtl/hbfa_pkg.sv
// Package for the harmonic bond force accumulator: payload types and FSM codes.
// No dependencies.
`timescale 1ns / 1ps
package hbfa_pkg;
    localparam int CW = 32;
    localparam int AW = 48;

    typedef struct packed {
        logic signed [CW-1:0] own_x;
        logic signed [CW-1:0] own_y;
        logic signed [CW-1:0] own_z;
        logic signed [CW-1:0] other_x;
        logic signed [CW-1:0] other_y;
        logic signed [CW-1:0] other_z;
        logic [CW-1:0]        rest_length;
        logic [CW-1:0]        stiffness;
        logic                 self_pair;
        logic                 last_bond;
    } t_bond;

    typedef struct packed {
        logic signed [AW-1:0] force_x;
        logic signed [AW-1:0] force_y;
        logic signed [AW-1:0] force_z;
        logic                 zero_distance_seen;
    } t_force;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT, S_MUL, S_DIV, S_ACC, S_OUT
    } t_state;
endpackage

>>> hw/rtl/hbfa_serial_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module hbfa_serial_mul #(
    parameter int AW = 64,
    parameter int BW = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic             o_done,
    output logic [AW+BW-1:0] o_p
);
    logic [AW+BW-1:0] r_acc, n_acc;
    logic [AW+BW-1:0] r_a;
    logic [BW-1:0]    r_b;
    logic [$clog2(BW+1)-1:0] r_cnt;
    logic             r_busy;

    // One conditional add of the shifted multiplicand per cycle.
    assign n_acc = r_b[0] ? r_acc + r_a : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_a    <= {{BW{1'b0}}, i_a};
                r_b    <= i_b;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_a   <= r_a << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(BW+1))'(BW-1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_p = r_acc;
endmodule

>>> hw/rtl/hbfa_serial_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module hbfa_serial_div #(
    parameter int NW = 128,
    parameter int DW = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    logic [NW-1:0] r_num;
    logic [DW:0]   r_rem;
    logic [DW+1:0] w_trial;
    logic [DW:0]   w_shift;
    logic [$clog2(NW+1)-1:0] r_cnt;
    logic          r_busy;

    assign w_shift = {r_rem[DW-1:0], r_num[NW-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_num  <= i_num;
            end else if (r_busy) begin
                // Remainder stays below the divisor, so DW+1 bits hold it.
                if (!w_trial[DW+1]) begin
                    r_rem <= w_trial[DW:0];
                    r_num <= {r_num[NW-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_num <= {r_num[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(NW+1))'(NW-1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_num;
endmodule

>>> hw/rtl/hbfa_isqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module hbfa_isqrt #(
    parameter int RW = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [RW-1:0]   i_rad,
    output logic            o_done,
    output logic [RW/2-1:0] o_root
);
    localparam int HW = RW / 2;
    logic [RW-1:0] r_rad;
    logic [HW+1:0] r_rem;
    logic [HW-1:0] r_root;
    logic [HW+1:0] w_cur;
    logic [HW+2:0] w_trial;
    logic [$clog2(HW+1)-1:0] r_cnt;
    logic          r_busy;

    assign w_cur   = {r_rem[HW-1:0], r_rad[RW-1:RW-2]};
    assign w_trial = {1'b0, w_cur} - {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_root <= '0;
                r_rad  <= i_rad;
            end else if (r_busy) begin
                r_rad <= r_rad << 2;
                if (!w_trial[HW+2]) begin
                    r_rem  <= w_trial[HW+1:0];
                    r_root <= {r_root[HW-2:0], 1'b1};
                end else begin
                    r_rem  <= w_cur;
                    r_root <= {r_root[HW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(HW+1))'(HW-1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_root = r_root;
endmodule

>>> hw/rtl/harmonic_bond_force_accumulator_unit.sv
// Top level of the harmonic bond force accumulator.
// Depends on hbfa_pkg, hbfa_serial_mul, hbfa_isqrt and hbfa_serial_div.
`timescale 1ns / 1ps
// One bond is taken per item and processed alone; the input is stalled while
// a bond is in work or a result is waiting. The separation vector is squared
// axis by axis in a bit-serial multiplier (three passes). The length comes
// from a bit-serial square root, and the force magnitude k*(r0-r) from one
// more multiplier pass. Each axis component f*d/r then needs a multiplier
// pass and a restoring divider pass of 80 quotient bits. A closing state
// follows. A bond with a nonzero separation keeps the input stalled until
// all of this is done, so the block takes no new bond before it is through
// with the last. The busy time is set by the serial multiplier and divider.
// A self pair or a bond with zero separation skips the serial units and goes
// straight back to idle, or to the output when it ends a particle. Each sum
// saturates to the signed 48-bit range. On an item marked last_bond the sums
// and the zero-distance flag are offered on the output, including that
// item's contribution, and then cleared. The next item is taken only after
// the output item has left.
module harmonic_bond_force_accumulator_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  hbfa_pkg::t_bond i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output hbfa_pkg::t_force o_data
);
    import hbfa_pkg::*;

    localparam int F   = 16;
    localparam int DW  = CW + 1;          // difference width
    localparam int QW  = 2 * DW + 2;      // sum of squares width
    localparam int RTW = QW / 2;          // root width
    localparam int FMW = AW - 1;          // saturated magnitude width
    localparam int PW  = FMW + DW;        // multiplier product width

    t_state r_state, n_state;
    t_bond  r_in;
    logic [DW-1:0] r_ax, r_ay, r_az;
    logic          r_sx, r_sy, r_sz;
    logic [QW-1:0] r_rr;
    logic [RTW-1:0] r_r;
    logic [FMW-1:0] r_fm;
    logic          r_dneg;
    logic [1:0]    r_axis;
    logic          r_phase;
    logic signed [AW-1:0] r_sum [3];
    logic          r_flag;
    logic          r_ovalid;

    // Shared multiplier: squares, then k*|delta|, then fm*|d|.
    logic          w_mstart, w_mdone;
    logic [FMW-1:0] w_ma;
    logic [DW-1:0] w_mb;
    logic [PW-1:0] w_mp;
    logic          w_sstart, w_sdone;
    logic [RTW-1:0] w_root;
    logic          w_dstart, w_ddone;
    logic [PW-1:0] w_quo;
    logic [DW-1:0] w_axsel;

    hbfa_serial_mul #(.AW(FMW), .BW(DW)) u_mul (
        .i_clk, .i_rst_n, .i_start(w_mstart), .i_a(w_ma), .i_b(w_mb),
        .o_done(w_mdone), .o_p(w_mp));
    hbfa_isqrt #(.RW(QW)) u_sqrt (
        .i_clk, .i_rst_n, .i_start(w_sstart), .i_rad(r_rr),
        .o_done(w_sdone), .o_root(w_root));
    // The divider takes the finished product on the multiplier's done cycle.
    hbfa_serial_div #(.NW(PW), .DW(RTW)) u_div (
        .i_clk, .i_rst_n, .i_start(w_dstart), .i_num(w_mp),
        .i_den(r_r), .o_done(w_ddone), .o_quo(w_quo));

    always_comb begin
        case (r_axis)
            2'd0:    w_axsel = r_ax;
            2'd1:    w_axsel = r_ay;
            default: w_axsel = r_az;
        endcase
    end

    // Differences are one bit wider than the coordinates.
    logic signed [DW-1:0] w_dx, w_dy, w_dz;
    assign w_dx = DW'(i_data.own_x) - DW'(i_data.other_x);
    assign w_dy = DW'(i_data.own_y) - DW'(i_data.other_y);
    assign w_dz = DW'(i_data.own_z) - DW'(i_data.other_z);

    // Delta r0 - r. The root stays below 2^33, so the magnitude fits in DW bits.
    logic signed [RTW+1:0] w_delta;
    logic [DW-1:0] w_dmag;
    assign w_delta = $signed((RTW+2)'(r_in.rest_length)) - $signed((RTW+2)'(r_r));
    assign w_dmag  = w_delta[RTW+1] ? DW'(-w_delta) : DW'(w_delta);

    // Product k*|delta| shifted down by F and saturated.
    logic [PW-1:0]  w_kp;
    logic [FMW-1:0] w_fm;
    assign w_kp = w_mp >> F;
    assign w_fm = (|w_kp[PW-1:FMW]) ? {FMW{1'b1}} : w_kp[FMW-1:0];

    // Signed contribution and saturating accumulate.
    logic          w_neg;
    logic signed [AW+1:0] w_c, w_s;
    logic signed [AW-1:0] w_sat;
    assign w_neg = r_dneg ^ (r_axis == 2'd0 ? r_sx : r_axis == 2'd1 ? r_sy : r_sz);
    assign w_c = w_neg ? -$signed({2'b00, w_quo[AW-1:0]})
                       : $signed({2'b00, w_quo[AW-1:0]});
    assign w_s = $signed({{2{r_sum[r_axis][AW-1]}}, r_sum[r_axis]}) + w_c;
    always_comb begin
        if (w_s > $signed({3'b000, {(AW-1){1'b1}}}))
            w_sat = {1'b0, {(AW-1){1'b1}}};
        else if (w_s < -$signed({3'b000, {(AW-1){1'b1}}}) - 1)
            w_sat = {1'b1, {(AW-1){1'b0}}};
        else
            w_sat = w_s[AW-1:0];
    end

    // Next-state logic. Each working state starts its unit in phase zero and
    // waits for the done pulse in phase one.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) begin
                if (i_data.self_pair || (w_dx == 0 && w_dy == 0 && w_dz == 0))
                    n_state = i_data.last_bond ? S_OUT : S_IDLE;
                else
                    n_state = S_SQ;
            end
            S_SQ:   if (r_phase && w_mdone && r_axis == 2'd2) n_state = S_SQRT;
            S_SQRT: if (r_phase && w_sdone) n_state = S_MUL;
            S_MUL:  if (r_phase && w_mdone) n_state = S_DIV;
            S_DIV:  if (w_ddone && r_axis == 2'd2) n_state = S_ACC;
            S_ACC:  n_state = r_in.last_bond ? S_OUT : S_IDLE;
            S_OUT:  if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Output and unit-start logic.
    always_comb begin
        o_stall  = 1'b1;
        w_mstart = 1'b0;
        w_sstart = 1'b0;
        w_dstart = 1'b0;
        w_ma     = '0;
        w_mb     = '0;
        case (r_state)
            S_IDLE: o_stall = 1'b0;
            S_SQ: begin
                w_ma = FMW'(w_axsel);
                w_mb = w_axsel;
                w_mstart = !r_phase;
            end
            S_SQRT: begin
                w_sstart = !r_phase;
            end
            S_MUL: begin
                w_ma = FMW'(r_in.stiffness);
                w_mb = w_dmag;
                w_mstart = !r_phase;
            end
            S_DIV: begin
                w_ma = r_fm;
                w_mb = w_axsel;
                w_mstart = !r_phase;
                w_dstart = r_phase && w_mdone;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= 1'b0;
            r_axis   <= '0;
            r_flag   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 3; i++) r_sum[i] <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_in   <= i_data;
                    r_ax   <= w_dx[DW-1] ? -w_dx : w_dx;
                    r_ay   <= w_dy[DW-1] ? -w_dy : w_dy;
                    r_az   <= w_dz[DW-1] ? -w_dz : w_dz;
                    r_sx   <= w_dx[DW-1];
                    r_sy   <= w_dy[DW-1];
                    r_sz   <= w_dz[DW-1];
                    r_rr   <= '0;
                    r_axis <= '0;
                    r_phase <= 1'b0;
                    if (!i_data.self_pair && w_dx == 0 && w_dy == 0 && w_dz == 0)
                        r_flag <= 1'b1;
                end
                S_SQ: begin
                    if (!r_phase) r_phase <= 1'b1;
                    else if (w_mdone) begin
                        r_rr    <= r_rr + QW'(w_mp);
                        r_phase <= 1'b0;
                        r_axis  <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                    end
                end
                S_SQRT: begin
                    // The root starts only after the last square is summed.
                    if (!r_phase) r_phase <= 1'b1;
                    else if (w_sdone) begin
                        r_r     <= w_root;
                        r_phase <= 1'b0;
                    end
                end
                S_MUL: begin
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                        r_dneg  <= w_delta[RTW+1];
                    end else if (w_mdone) begin
                        r_fm    <= w_fm;
                        r_phase <= 1'b0;
                        r_axis  <= '0;
                    end
                end
                S_DIV: begin
                    if (!r_phase) r_phase <= 1'b1;
                    else if (w_ddone) begin
                        r_sum[r_axis] <= w_sat;
                        r_phase <= 1'b0;
                        r_axis  <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                    end
                end
                S_OUT: if (!i_stall) begin
                    r_flag <= 1'b0;
                    for (int i = 0; i < 3; i++) r_sum[i] <= '0;
                end
                default: ;
            endcase
            r_ovalid <= (n_state == S_OUT);
        end
    end

    always_comb begin
        o_data.force_x = r_sum[0];
        o_data.force_y = r_sum[1];
        o_data.force_z = r_sum[2];
        o_data.zero_distance_seen = r_flag;
    end
    assign o_valid = r_ovalid;
endmodule

>>> test/tb.sv
// Self-checking testbench for harmonic_bond_force_accumulator_unit.
// Depends on hbfa_pkg and the unit; runs directed and random bonds against its own predictor.
`timescale 1ns / 1ps
module tb;
    import hbfa_pkg::*;

    localparam int  HOLD_CYCLES  = 3000;
    localparam int  WDOG_LIMIT   = 20000;
    localparam int  DRAIN_CYCLES = 800;
    localparam int  FRAC_SHIFT   = 16;
    localparam longint FORCE_MAX = (64'sd1 <<< (AW - 1)) - 1;
    localparam longint FORCE_MIN = -FORCE_MAX - 1;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   o_stall;
    t_bond  i_data = '0;
    logic   o_valid;
    logic   i_stall = 1'b1;
    t_force o_data;

    // Idle percentages for sender and receiver, and a receiver hold-off request.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int fail_count    = 0;
    int quiet_cycles  = 0;

    // Running per-particle sums of the predictor.
    longint acc_x = 0, acc_y = 0, acc_z = 0;
    logic   zero_dist_flag = 1'b0;
    t_force expected_forces[$];

    harmonic_bond_force_accumulator_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic longint clamp_add(longint s, longint c);
        longint t;
        t = s + c;
        if (t > FORCE_MAX) return FORCE_MAX;
        if (t < FORCE_MIN) return FORCE_MIN;
        return t;
    endfunction

    // Works out one bond's spring contribution and, on the last bond, the
    // emitted force item. All intermediate products are exact in 128 bits.
    function automatic void predict_bond(t_bond b);
        longint      d[3];
        logic [63:0] a[3];
        logic [127:0] rr, p, q;
        logic [63:0] len, cand, fm, dmag, r0, k;
        longint      delta, contrib[3];
        logic        neg;
        t_force      f;
        d[0] = longint'(b.own_x) - longint'(b.other_x);
        d[1] = longint'(b.own_y) - longint'(b.other_y);
        d[2] = longint'(b.own_z) - longint'(b.other_z);
        if (!b.self_pair) begin
            for (int i = 0; i < 3; i++) begin
                a[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
            end
            rr = 128'(a[0]) * 128'(a[0]) + 128'(a[1]) * 128'(a[1])
               + 128'(a[2]) * 128'(a[2]);
            if (rr == 0) begin
                zero_dist_flag = 1'b1;
            end else begin
                // Bitwise integer square root, floor.
                len = 0;
                for (int bt = 52; bt >= 0; bt--) begin
                    cand = len | (64'd1 << bt);
                    if (128'(cand) * 128'(cand) <= rr) len = cand;
                end
                r0 = 64'(b.rest_length);
                k  = 64'(b.stiffness);
                delta = longint'(r0) - longint'(len);
                dmag = delta < 0 ? 64'(-delta) : 64'(delta);
                p = (128'(k) * 128'(dmag)) >> FRAC_SHIFT;
                fm = p > 128'(FORCE_MAX) ? 64'(FORCE_MAX) : p[63:0];
                for (int i = 0; i < 3; i++) begin
                    q = (128'(fm) * 128'(a[i])) / 128'(len);
                    neg = (delta < 0) != (d[i] < 0);
                    contrib[i] = neg ? -longint'(q[63:0]) : longint'(q[63:0]);
                end
                acc_x = clamp_add(acc_x, contrib[0]);
                acc_y = clamp_add(acc_y, contrib[1]);
                acc_z = clamp_add(acc_z, contrib[2]);
            end
        end
        if (b.last_bond) begin
            f.force_x = acc_x[AW-1:0];
            f.force_y = acc_y[AW-1:0];
            f.force_z = acc_z[AW-1:0];
            f.zero_distance_seen = zero_dist_flag;
            expected_forces.insert(expected_forces.size(), f);
            acc_x = 0;
            acc_y = 0;
            acc_z = 0;
            zero_dist_flag = 1'b0;
        end
    endfunction

    // Input monitor: every accepted bond goes through the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) predict_bond(i_data);
    end

    // Output checker: each accepted force item is compared with the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        t_force e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_forces.size() == 0) begin
                $error("force item with no expectation pending");
                fail_count++;
            end else begin
                e = expected_forces.pop_front();
                if (o_data.force_x !== e.force_x) begin
                    $error("force_x expected %0d got %0d", e.force_x, o_data.force_x);
                    fail_count++;
                end
                if (o_data.force_y !== e.force_y) begin
                    $error("force_y expected %0d got %0d", e.force_y, o_data.force_y);
                    fail_count++;
                end
                if (o_data.force_z !== e.force_z) begin
                    $error("force_z expected %0d got %0d", e.force_z, o_data.force_z);
                    fail_count++;
                end
                if (o_data.zero_distance_seen !== e.zero_distance_seen) begin
                    $error("zero_distance_seen expected %0d got %0d",
                           e.zero_distance_seen, o_data.zero_distance_seen);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: ends the run when nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sends one bond item; valid stays high afterwards until the next gap.
    task automatic send_bond(t_bond b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_all_forces();
        while (expected_forces.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_bond make_bond(int style, logic last);
        t_bond b;
        int    spread;
        b.own_x = $urandom;
        b.own_y = $urandom;
        b.own_z = $urandom;
        case (style)
            0: begin
                // Nearby partner, the usual molecular geometry.
                spread = $urandom_range(20, 4);
                b.own_x = $signed(b.own_x) >>> 6;
                b.own_y = $signed(b.own_y) >>> 6;
                b.own_z = $signed(b.own_z) >>> 6;
                b.other_x = b.own_x + ($signed(32'($urandom)) >>> (32 - spread));
                b.other_y = b.own_y + ($signed(32'($urandom)) >>> (32 - spread));
                b.other_z = b.own_z + ($signed(32'($urandom)) >>> (32 - spread));
            end
            1: begin
                b.other_x = $urandom;
                b.other_y = $urandom;
                b.other_z = $urandom;
            end
            default: begin
                b.other_x = b.own_x;
                b.other_y = b.own_y;
                b.other_z = b.own_z;
            end
        endcase
        if ($urandom_range(9) < 8) begin
            b.rest_length = $urandom_range(32'h0040_0000, 1);
            b.stiffness   = $urandom_range(32'h0010_0000, 1);
        end else begin
            b.rest_length = $urandom;
            b.stiffness   = $urandom;
        end
        b.self_pair = ($urandom_range(9) == 0);
        b.last_bond = last;
        return b;
    endfunction

    // One particle: a few bonds with the last one marked.
    task automatic send_particle();
        int n, style, pick;
        n = $urandom_range(5, 1);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            style = pick < 75 ? 0 : (pick < 93 ? 1 : 2);
            send_bond(make_bond(style, i == n - 1));
        end
    endtask

    task automatic test_directed();
        t_bond b;
        // Opposite corners with the widest values and huge stiffness.
        b = '0;
        b.own_x = 32'h7fff_ffff; b.own_y = 32'h8000_0000; b.own_z = 32'h7fff_ffff;
        b.other_x = 32'h8000_0000; b.other_y = 32'h7fff_ffff; b.other_z = 32'h8000_0000;
        b.rest_length = 32'hffff_ffff; b.stiffness = 32'hffff_ffff;
        for (int i = 0; i < 6; i++) begin
            b.last_bond = (i == 5);
            send_bond(b);
        end
        // Stretched bond pulling back, minimum rest length and stiffness.
        b = '0;
        b.other_x = 32'h0003_0000; b.rest_length = 32'd1; b.stiffness = 32'd1;
        b.last_bond = 1'b1;
        send_bond(b);
        // Zero stiffness adds nothing.
        b.stiffness = '0; b.rest_length = 32'h0001_0000;
        send_bond(b);
        // Zero separation sets the flag, then a normal bond in the same particle.
        b = '0;
        b.own_x = 32'h1234_0000; b.other_x = 32'h1234_0000;
        b.rest_length = 32'h0001_0000; b.stiffness = 32'h0001_0000;
        send_bond(b);
        b.other_x = 32'h1235_8000; b.last_bond = 1'b1;
        send_bond(b);
        // Self pair with zero separation: no flag, still emits.
        b.other_x = b.own_x; b.self_pair = 1'b1;
        send_bond(b);
        // Self pair with a real separation contributes nothing.
        b.other_y = 32'h8000_0000; b.stiffness = 32'hffff_ffff;
        send_bond(b);
        // Bond at exactly its rest length.
        b = '0;
        b.other_z = 32'hfffe_0000; b.rest_length = 32'h0002_0000;
        b.stiffness = 32'h0100_0000; b.last_bond = 1'b1;
        send_bond(b);
        // Separation whose length rounds down to exactly the rest length: no force despite huge stiffness.
        b = '0;
        b.own_x = 32'h8000_0000; b.other_x = 32'h7fff_ffff;
        b.own_z = 32'h0000_0001; b.rest_length = 32'hffff_ffff;
        b.stiffness = 32'hffff_ffff;
        for (int i = 0; i < 6; i++) begin
            b.last_bond = (i == 5);
            send_bond(b);
        end
        i_valid <= 1'b0;
        wait_all_forces();
    endtask

    task automatic test_random(int bonds, int s_pct, int r_pct);
        int sent_before;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent_before = 0;
        while (sent_before < bonds) begin
            send_particle();
            sent_before += 3;
        end
        i_valid <= 1'b0;
        wait_all_forces();
    endtask

    // Receiver stops for a long stretch while whole particles keep coming,
    // so the block backs up and stalls its input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 6; i++) begin
            send_bond(make_bond(0, 1'b1));
        end
        i_valid <= 1'b0;
        wait_all_forces();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        recv_idle_pct = 30;
        test_directed();
        test_random(150, 19, 53);
        test_random(150, 53, 19);
        test_backpressure();
        test_random(150, 0, 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_forces.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
